// ===== rtl/ook_pulse_width_frame_encoder_defines.svh =====
// Assertion macros for the pulse-width frame encoder checker.
// Depends on nothing; included by the checker file only.
`ifndef OOK_PULSE_WIDTH_FRAME_ENCODER_DEFINES_SVH
`define OOK_PULSE_WIDTH_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define OOKPWE_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("same-cycle rule broken");

// Next-cycle implication, sampled on i_clk, off during reset.
`define OOKPWE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("next-cycle rule broken");

`endif

// ===== rtl/ookpwe_pkg.sv =====
// Shared types, constants and the part length function of the frame encoder.
// Depends on nothing.
package ookpwe_pkg;

    localparam int WordBits  = 20;
    localparam int CodeWidth = 20;
    localparam int PosWidth  = $clog2(WordBits + 1);
    localparam int RepWidth  = 8;
    localparam int LongWidth = 4;
    localparam int GapWidth  = 6;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 8;

    localparam logic [RepWidth-1:0]  RepeatReset = RepWidth'(5);
    localparam logic [LongWidth-1:0] LongReset   = LongWidth'(3);
    localparam logic [GapWidth-1:0]  GapReset    = GapWidth'(31);

    typedef enum logic {
        ActTick  = 1'b0,
        ActStart = 1'b1
    } t_action;

    typedef enum logic [CfgIdxW-1:0] {
        RegRepeatCount = 2'd0,
        RegLongUnits   = 2'd1,
        RegGapUnits    = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic                is_start;
        logic [WordBits-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic [RepWidth-1:0]  repeat_count;
        logic [LongWidth-1:0] long_units;
        logic [GapWidth-1:0]  gap_units;
    } t_cfg;

    function automatic logic [GapWidth-1:0] f_part_len(
        input logic [PosWidth-1:0]  pos,
        input logic                 high,
        input logic                 top,
        input logic [LongWidth-1:0] long_u,
        input logic [GapWidth-1:0]  gap_u
    );
        logic [LongWidth-1:0] l1;
        logic [GapWidth-1:0]  g1;
        logic [GapWidth-1:0]  res;
        l1 = (long_u == '0) ? LongWidth'(1) : long_u;
        g1 = (gap_u == '0) ? GapWidth'(1) : gap_u;
        if (pos >= PosWidth'(WordBits)) begin
            res = high ? g1 : GapWidth'(1);
        end else if (high != top) begin
            res = GapWidth'(l1);
        end else begin
            res = GapWidth'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/ookpwe_front.sv =====
// Input side: accepts items, classifies them and holds them in a two-entry queue.
// Depends on ookpwe_pkg.
module ookpwe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [ookpwe_pkg::CodeWidth-1:0] i_code_word,
    output logic                          o_cmd_valid,
    output ookpwe_pkg::t_cmd              o_cmd,
    input  logic                          i_cmd_pop
);
    import ookpwe_pkg::*;

    t_cmd       r_entry [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_cmd       new_cmd;

    assign o_in_ready  = (r_count != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_entry[r_rptr];

    always_comb begin
        new_cmd.is_start = (t_action'(i_action) == ActStart);
        new_cmd.word     = i_code_word[WordBits-1:0];
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = i_cmd_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wptr] <= new_cmd;
        end
    end

endmodule

// ===== rtl/ookpwe_back.sv =====
// Execution side: walks the line state per item and registers one result per item.
// Depends on ookpwe_pkg.
module ookpwe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ookpwe_pkg::t_cfg i_cfg,
    input  logic             i_cmd_valid,
    input  ookpwe_pkg::t_cmd i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_line_level,
    output logic             o_busy_res,
    output logic             o_frame_done
);
    import ookpwe_pkg::*;

    logic [WordBits-1:0] r_word,  n_word;
    logic [PosWidth-1:0] r_pos,   n_pos;
    logic [RepWidth-1:0] r_rep,   n_rep;
    logic                r_high,  n_high;
    logic [GapWidth-1:0] r_units, n_units;
    logic                r_send,  n_send;
    logic                r_out_valid;
    logic                r_line, r_busy, r_done;
    logic                n_done;
    logic                reload;
    logic [WordBits-1:0] rot_word;

    assign o_cmd_pop    = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_line;
    assign o_busy_res   = r_busy;
    assign o_frame_done = r_done;

    assign rot_word = (r_word << 1) | (r_word >> (WordBits - 1));

    always_comb begin
        n_word  = r_word;
        n_pos   = r_pos;
        n_rep   = r_rep;
        n_high  = r_high;
        n_units = r_units;
        n_send  = r_send;
        n_done  = 1'b0;
        reload  = 1'b0;
        if (i_cmd.is_start) begin
            if (!r_send) begin
                n_word = i_cmd.word;
                n_pos  = '0;
                n_rep  = (i_cfg.repeat_count == '0) ? RepWidth'(1) : i_cfg.repeat_count;
                n_high = 1'b0;
                n_send = 1'b1;
                reload = 1'b1;
            end
        end else if (r_send) begin
            if (r_units > GapWidth'(1)) begin
                n_units = r_units - GapWidth'(1);
            end else if (!r_high) begin
                n_high = 1'b1;
                reload = 1'b1;
            end else begin
                n_high = 1'b0;
                if (r_pos < PosWidth'(WordBits)) begin
                    n_word = rot_word;
                    n_pos  = r_pos + PosWidth'(1);
                    reload = 1'b1;
                end else if (r_rep > RepWidth'(1)) begin
                    n_rep  = r_rep - RepWidth'(1);
                    n_pos  = '0;
                    reload = 1'b1;
                end else begin
                    n_rep   = '0;
                    n_pos   = '0;
                    n_units = '0;
                    n_send  = 1'b0;
                    n_done  = 1'b1;
                end
            end
        end
        if (reload) begin
            n_units = f_part_len(n_pos, n_high, n_word[WordBits-1],
                                 i_cfg.long_units, i_cfg.gap_units);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_pos       <= '0;
            r_rep       <= '0;
            r_high      <= 1'b0;
            r_units     <= '0;
            r_send      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_word  <= n_word;
                r_pos   <= n_pos;
                r_rep   <= n_rep;
                r_high  <= n_high;
                r_units <= n_units;
                r_send  <= n_send;
            end
            if (o_cmd_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_line <= n_send ? n_high : 1'b1;
            r_busy <= n_send;
            r_done <= n_done;
        end
    end

endmodule

// ===== rtl/ook_pulse_width_frame_encoder.sv =====
// Pulse-width OOK frame encoder: top level with configuration registers.
// Depends on ookpwe_pkg, ookpwe_front and ookpwe_back.
//
// Each input item (a start carrying a 20-bit code word, or a tick of one base
// unit) yields exactly one result: the line level for the coming unit, busy and
// frame-done. One item is taken per clock cycle while the output is not stalled,
// and results leave at the same rate; an item passes the two-entry input queue and
// then the output register, and the back end updates its state once per item, which
// sets the rate. Configuration writes are taken in any cycle (ready is always high);
// lengths are read as each part begins and the repeat count at start.
module ook_pulse_width_frame_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ookpwe_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [ookpwe_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [ookpwe_pkg::CodeWidth-1:0] i_code_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_line_level,
    output logic                             o_busy_res,
    output logic                             o_frame_done
);
    import ookpwe_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                RegRepeatCount: n_cfg.repeat_count = i_cfg_data[RepWidth-1:0];
                RegLongUnits:   n_cfg.long_units   = i_cfg_data[LongWidth-1:0];
                RegGapUnits:    n_cfg.gap_units    = i_cfg_data[GapWidth-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_count <= RepeatReset;
            r_cfg.long_units   <= LongReset;
            r_cfg.gap_units    <= GapReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ookpwe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_code_word (i_code_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ookpwe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done)
    );

endmodule

// ===== rtl/ookpwe_checker.sv =====
// Port-level checker for the frame encoder, bound to the top level.
// Depends on ook_pulse_width_frame_encoder_defines.svh.
`include "ook_pulse_width_frame_encoder_defines.svh"

module ookpwe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_line_level,
    input logic o_busy_res,
    input logic o_frame_done
);

    `OOKPWE_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready)
    `OOKPWE_ASSERT_NOW(a_done_idle, o_out_valid && o_frame_done, !o_busy_res)
    `OOKPWE_ASSERT_NOW(a_idle_high, o_out_valid && !o_busy_res, o_line_level)
    `OOKPWE_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `OOKPWE_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable({o_line_level, o_busy_res, o_frame_done}))

endmodule

bind ook_pulse_width_frame_encoder ookpwe_checker u_ookpwe_checker (.*);

// ===== tb/sv/tb_ook_pulse_width_frame_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pulse-width OOK frame encoder: directed and random
// start/tick items, an item-by-item line predictor, and random stalls on both channels.
// Depends on ookpwe_pkg and the ook_pulse_width_frame_encoder RTL.
module tb_ook_pulse_width_frame_encoder;
    import ookpwe_pkg::*;

    localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
    localparam int unsigned HoldoffCycles = 80;

    typedef struct {
        t_action              act;
        logic [CodeWidth-1:0] word;
    } t_frame_item;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } t_line_state;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index  = '0;
    logic [CfgDataW-1:0]  i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic                 i_action     = 1'b0;
    logic [CodeWidth-1:0] i_code_word  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_line_level;
    logic                 o_busy_res;
    logic                 o_frame_done;

    t_frame_item pending_q[$];
    t_line_state expected_line_q[$];
    t_frame_item next_item;
    logic        in_taken = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned holdoff_req = 0;
    int unsigned holdoff_seen = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int          items_sent = 0;
    int          fail_count = 0;

    logic [RepWidth-1:0]  cfg_repeat = RepeatReset;
    logic [LongWidth-1:0] cfg_long   = LongReset;
    logic [GapWidth-1:0]  cfg_gap    = GapReset;

    logic [WordBits-1:0]  enc_word    = '0;
    logic [PosWidth-1:0]  enc_pos     = '0;
    logic [RepWidth-1:0]  enc_reps    = '0;
    logic                 enc_high    = 1'b0;
    logic [GapWidth-1:0]  enc_units   = '0;
    logic                 enc_sending = 1'b0;

    ook_pulse_width_frame_encoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_code_word  (i_code_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned gap_len(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CodeWidth-1:0] random_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CodeWidth'($urandom);
    endfunction

    // Units in the part that begins now, from the current symbol and register values.
    function automatic logic [GapWidth-1:0] part_units();
        logic [GapWidth-1:0] lng;
        logic [GapWidth-1:0] gp;
        logic                bit_now;
        lng     = (cfg_long == '0) ? GapWidth'(1) : GapWidth'(cfg_long);
        gp      = (cfg_gap == '0) ? GapWidth'(1) : cfg_gap;
        bit_now = enc_word[WordBits-1];
        if (enc_pos >= PosWidth'(WordBits)) return enc_high ? gp : GapWidth'(1);
        if (enc_high) return bit_now ? GapWidth'(1) : lng;
        return bit_now ? lng : GapWidth'(1);
    endfunction

    function automatic int frame_len();
        int lng;
        int gp;
        int reps;
        lng  = (cfg_long == '0) ? 1 : int'(cfg_long);
        gp   = (cfg_gap == '0) ? 1 : int'(cfg_gap);
        reps = (cfg_repeat == '0) ? 1 : int'(cfg_repeat);
        return reps * (WordBits * (1 + lng) + 1 + gp);
    endfunction

    task automatic encode_item(input t_action act, input logic [CodeWidth-1:0] word);
        t_line_state res;
        logic        done;
        done = 1'b0;
        if (act == ActStart) begin
            if (!enc_sending) begin
                enc_word    = word;
                enc_pos     = '0;
                enc_reps    = (cfg_repeat == '0) ? RepWidth'(1) : cfg_repeat;
                enc_high    = 1'b0;
                enc_sending = 1'b1;
                enc_units   = part_units();
            end
        end else if (enc_sending) begin
            if (enc_units > 1) begin
                enc_units = enc_units - 1'b1;
            end else if (!enc_high) begin
                enc_high  = 1'b1;
                enc_units = part_units();
            end else begin
                enc_high = 1'b0;
                if (enc_pos < PosWidth'(WordBits)) begin
                    enc_word  = {enc_word[WordBits-2:0], enc_word[WordBits-1]};
                    enc_pos   = enc_pos + 1'b1;
                    enc_units = part_units();
                end else if (enc_reps > 1) begin
                    enc_reps  = enc_reps - 1'b1;
                    enc_pos   = '0;
                    enc_units = part_units();
                end else begin
                    enc_reps    = '0;
                    enc_pos     = '0;
                    enc_units   = '0;
                    enc_sending = 1'b0;
                    done        = 1'b1;
                end
            end
        end
        res.level = enc_sending ? enc_high : 1'b1;
        res.busy  = enc_sending;
        res.done  = done;
        expected_line_q.push_back(res);
    endtask

    always @(posedge i_clk) begin : check_and_predict
        t_line_state want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    RegRepeatCount: cfg_repeat = i_cfg_data[RepWidth-1:0];
                    RegLongUnits:   cfg_long   = i_cfg_data[LongWidth-1:0];
                    RegGapUnits:    cfg_gap    = i_cfg_data[GapWidth-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_line_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_line_q.pop_front();
                    if (o_line_level !== want.level) begin
                        $error("line_level: expected %0b, got %0b", want.level, o_line_level);
                        fail_count++;
                    end
                    if (o_busy_res !== want.busy) begin
                        $error("busy_res: expected %0b, got %0b", want.busy, o_busy_res);
                        fail_count++;
                    end
                    if (o_frame_done !== want.done) begin
                        $error("frame_done: expected %0b, got %0b", want.done, o_frame_done);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                encode_item(t_action'(i_action), i_code_word);
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold until the transfer
        end else if (tx_gap != 0) begin
            i_in_valid <= 1'b0;
            tx_gap     <= tx_gap - 1;
        end else if (pending_q.size() != 0) begin
            next_item    = pending_q.pop_front();
            i_in_valid  <= 1'b1;
            i_action    <= next_item.act;
            i_code_word <= next_item.word;
            tx_gap      <= gap_len(tx_steady);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_seen != holdoff_req) begin
            i_out_ready  <= 1'b0;
            rx_stall     <= HoldoffCycles - 1;
            holdoff_seen <= holdoff_req;
        end else if (rx_stall != 0) begin
            i_out_ready <= 1'b0;
            rx_stall    <= rx_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            rx_stall    <= gap_len(rx_steady);
        end
    end

    task automatic push_item(input t_action act, input logic [CodeWidth-1:0] word);
        t_frame_item it;
        it.act  = act;
        it.word = word;
        pending_q.push_back(it);
        items_sent++;
    endtask

    task automatic push_ticks(input int count);
        for (int k = 0; k < count; k++) begin
            push_item(ActTick, random_word());
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic end_cfg();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        bit feeding;
        do begin
            @(posedge i_clk);
            feeding = (pending_q.size() != 0) || i_in_valid;
            @(negedge i_clk);
        end while (feeding || expected_line_q.size() != 0);
    endtask

    // Tick out whatever frame is still running so the next start is taken.
    task automatic flush_frame();
        while (enc_sending) begin
            @(posedge i_clk);
            push_ticks(16);
            wait_drained();
        end
    endtask

    task automatic run_phase(input logic [RepWidth-1:0] rep, input logic [LongWidth-1:0] lng,
                             input logic [GapWidth-1:0] gp, input int frames, input bit holdoff);
        int r;
        int n;
        write_reg(RegRepeatCount, rep);
        write_reg(RegLongUnits, {4'($urandom), lng});
        write_reg(RegGapUnits, {2'($urandom), gp});
        if ($urandom_range(0, 3) == 0) write_reg(RegUnused, 8'($urandom));
        end_cfg();
        @(posedge i_clk);
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        if (holdoff) holdoff_req++;
        for (int f = 0; f < frames; f++) begin
            r = $urandom_range(0, 99);
            n = frame_len();
            if (r < 80) begin
                push_item(ActStart, random_word());
                for (int k = 0; k < n; k++) begin
                    push_item(ActTick, random_word());
                    if ($urandom_range(0, 24) == 0) push_item(ActStart, random_word());
                end
                push_ticks($urandom_range(0, 3));
            end else if (r < 90) begin
                push_item(ActStart, random_word());
                push_ticks($urandom_range(1, n - 1));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_item(t_action'($urandom_range(0, 1)), random_word());
                end
            end
            wait_drained();
            flush_frame();
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero lengths and repeat count, upper data bits set, unknown register
        write_reg(RegRepeatCount, 8'h00);
        write_reg(RegLongUnits, 8'hF0);
        write_reg(RegGapUnits, 8'hC0);
        write_reg(RegUnused, 8'hFF);
        end_cfg();
        @(posedge i_clk);
        push_item(ActTick, '1);
        push_item(ActTick, '0);
        push_item(ActStart, '1);
        push_item(ActStart, '0);
        push_ticks(8);
        push_item(ActStart, 20'h5A5A5);
        push_ticks(12);
        wait_drained();
        flush_frame();

        run_phase(8'd1, 4'd2, 6'd1, 1, 1'b0);
        run_phase(8'd1, 4'd15, 6'd63, 1, 1'b1);
        while (items_sent < 600) begin
            run_phase(RepWidth'($urandom_range(1, 2)),
                      LongWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1)
                                                             : $urandom_range(2, 3)),
                      GapWidth'($urandom_range(0, 6)),
                      $urandom_range(1, 2), $urandom_range(0, 2) == 0);
        end

        // longest repeat count: start and leave the frame running
        run_phase(8'd255, 4'd2, 6'd1, 0, 1'b1);
        push_item(ActStart, random_word());
        push_ticks(30);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ookpwe_pkg.sv
rtl/ookpwe_front.sv
rtl/ookpwe_back.sv
rtl/ook_pulse_width_frame_encoder.sv
rtl/ookpwe_checker.sv
tb/sv/tb_ook_pulse_width_frame_encoder.sv
